### rtl/core/kpe_pkg.sv
// ----------------------------------------------------------------------------
// kpe_pkg
// Shared types, codes and constants of the key press event classifier.
// ----------------------------------------------------------------------------
package kpe_pkg;

  // key count and the key that also reports a long hold
  localparam int unsigned NUM_KEYS       = 6;
  localparam int unsigned HOLD_KEY_INDEX = 2;

  // field widths
  localparam int unsigned KeyW    = 3;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned LevelW  = 6;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned TickW   = 10;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned ModesW  = 18;
  localparam int unsigned ActW    = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 18;

  // counter cap and long hold mark, ms
  localparam logic [TimeW-1:0] CntCap = 16'd60000;
  localparam logic [TimeW-1:0] HoldMs = 16'd8000;

  // result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [ModeW-1:0] {
    ModeOff    = 3'd0,
    ModeCont   = 3'd1,
    ModeRepeat = 3'd2,
    ModeSingle = 3'd3,
    ModeDual   = 3'd4,
    ModeTreble = 3'd5
  } mode_e;

  typedef enum logic [CodeW-1:0] {
    EvPrimary = 3'd0,
    EvLong    = 3'd1,
    EvLongRel = 3'd2,
    EvDouble  = 3'd3,
    EvHold    = 3'd4
  } ev_code_e;

  typedef enum logic [ActW-1:0] {
    ActNone    = 2'd0,
    ActPrimary = 2'd1,
    ActLong    = 2'd2,
    ActDouble  = 2'd3
  } act_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTickMs      = 3'd0,
    CfgRepeatDelay = 3'd1,
    CfgRepeatRate  = 3'd2,
    CfgShortLimit  = 3'd3,
    CfgLongTime    = 3'd4,
    CfgClickGap    = 3'd5,
    CfgKeyModes    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [TickW-1:0]  tick_ms;
    logic [TimeW-1:0]  repeat_delay;
    logic [TimeW-1:0]  repeat_rate;
    logic [TimeW-1:0]  short_press_limit;
    logic [TimeW-1:0]  long_press_time;
    logic [TimeW-1:0]  click_gap_limit;
    logic [ModesW-1:0] key_modes;
  } cfg_t;

  // one memory entry: the state of one key
  typedef struct packed {
    logic [TimeW-1:0] press;
    logic [TimeW-1:0] release_ms;
    logic [ActW-1:0]  prior;
  } key_state_t;

  // evaluation result of one key
  typedef struct packed {
    key_state_t       next;
    logic             ev_valid;
    logic [CodeW-1:0] ev_code;
    logic             hold;
  } key_eval_t;

  // one queued result
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [CodeW-1:0] code;
    logic             last;
  } out_item_t;

endpackage

### rtl/core/kpe_cfg_regs.sv
// ----------------------------------------------------------------------------
// kpe_cfg_regs
// Configuration register file, written one register per request.
// ----------------------------------------------------------------------------
module kpe_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [kpe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kpe_pkg::CfgDatW-1:0]  cfg_data_i,
  output kpe_pkg::cfg_t                cfg_o
);
  import kpe_pkg::*;

  cfg_t cfg_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_ms           <= 10'd10;
      cfg_q.repeat_delay      <= 16'd500;
      cfg_q.repeat_rate       <= 16'd100;
      cfg_q.short_press_limit <= 16'd500;
      cfg_q.long_press_time   <= 16'd1500;
      cfg_q.click_gap_limit   <= 16'd300;
      cfg_q.key_modes         <= 18'd153892;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTickMs:      cfg_q.tick_ms           <= cfg_data_i[TickW-1:0];
        CfgRepeatDelay: cfg_q.repeat_delay      <= cfg_data_i[TimeW-1:0];
        CfgRepeatRate:  cfg_q.repeat_rate       <= cfg_data_i[TimeW-1:0];
        CfgShortLimit:  cfg_q.short_press_limit <= cfg_data_i[TimeW-1:0];
        CfgLongTime:    cfg_q.long_press_time   <= cfg_data_i[TimeW-1:0];
        CfgClickGap:    cfg_q.click_gap_limit   <= cfg_data_i[TimeW-1:0];
        CfgKeyModes:    cfg_q.key_modes         <= cfg_data_i[ModesW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/kpe_state_mem.sv
// ----------------------------------------------------------------------------
// kpe_state_mem
// Per-key state memory: one write and one registered read port, with a
// valid bit per entry so that reset clears every key at once.
// ----------------------------------------------------------------------------
module kpe_state_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [kpe_pkg::KeyW-1:0]  rd_addr_i,
  output kpe_pkg::key_state_t       rd_data_o,
  input  logic                      wr_en_i,
  input  logic [kpe_pkg::KeyW-1:0]  wr_addr_i,
  input  kpe_pkg::key_state_t       wr_data_i
);
  import kpe_pkg::*;

  key_state_t          mem_q [NUM_KEYS];
  logic [NUM_KEYS-1:0] valid_q;
  key_state_t          rdata_q;
  logic                rvalid_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // registered read, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else if (rd_en_i) begin
      rvalid_q <= valid_q[rd_addr_i];
    end
  end

  // an entry never written reads as the reset state
  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

### rtl/core/kpe_key_eval.sv
// ----------------------------------------------------------------------------
// kpe_key_eval
// Update of one key per scan: counters, mode event, long hold flag and the
// state to write back.
// ----------------------------------------------------------------------------
module kpe_key_eval (
  input  kpe_pkg::cfg_t              cfg_i,
  input  logic [kpe_pkg::KeyW-1:0]   key_i,
  input  logic                       down_i,
  input  logic [kpe_pkg::ModeW-1:0]  mode_i,
  input  kpe_pkg::key_state_t        cur_i,
  output kpe_pkg::key_eval_t         eval_o
);
  import kpe_pkg::*;

  logic [TimeW-1:0] press_d;
  logic [TimeW-1:0] rel_d;
  logic [ActW-1:0]  prior_d;
  logic [TimeW-1:0] tick;
  logic [TimeW:0]   repeat_mark;
  logic             rel_press;
  logic             hold_key;

  assign tick        = TimeW'(cfg_i.tick_ms);
  assign repeat_mark = {1'b0, cfg_i.repeat_delay} + {1'b0, cfg_i.repeat_rate};
  assign hold_key    = (HOLD_KEY_INDEX < NUM_KEYS) && (key_i == KeyW'(HOLD_KEY_INDEX));

  always_comb begin
    press_d         = cur_i.press;
    rel_d           = cur_i.release_ms;
    prior_d         = cur_i.prior;
    rel_press       = 1'b0;
    eval_o.ev_valid = 1'b0;
    eval_o.ev_code  = EvPrimary;
    eval_o.hold     = 1'b0;

    if (mode_i != ModeOff) begin
      // saturating-start counters
      if (down_i) begin
        if (cur_i.press < CntCap) press_d = cur_i.press + tick;
      end else begin
        if (cur_i.release_ms < CntCap) rel_d = cur_i.release_ms + tick;
      end
      rel_press = (press_d != '0) && !down_i;

      // mode events
      case (mode_i)
        ModeCont: begin
          if (down_i) begin
            eval_o.ev_valid = 1'b1;
            prior_d         = ActPrimary;
          end
        end
        ModeRepeat: begin
          if (rel_press && press_d < cfg_i.repeat_delay) begin
            eval_o.ev_valid = 1'b1;
            prior_d         = ActPrimary;
          end else if (down_i && {1'b0, press_d} > repeat_mark) begin
            eval_o.ev_valid = 1'b1;
            press_d         = press_d - cfg_i.repeat_rate;
            prior_d         = ActPrimary;
          end
        end
        ModeSingle: begin
          if (rel_press) begin
            eval_o.ev_valid = 1'b1;
            prior_d         = ActPrimary;
          end
        end
        ModeDual: begin
          if (rel_press && press_d < cfg_i.short_press_limit) begin
            eval_o.ev_valid = 1'b1;
            prior_d         = ActPrimary;
          end else if (down_i && press_d == cfg_i.long_press_time) begin
            eval_o.ev_valid = 1'b1;
            eval_o.ev_code  = EvLong;
            prior_d         = ActLong;
          end else if (rel_press && press_d > cfg_i.long_press_time) begin
            eval_o.ev_valid = 1'b1;
            eval_o.ev_code  = EvLongRel;
          end
        end
        ModeTreble: begin
          // a lone click resolves once the gap has run out
          if (press_d == '0 && !down_i && rel_d > cfg_i.click_gap_limit &&
              cur_i.prior == ActPrimary) begin
            eval_o.ev_valid = 1'b1;
            prior_d         = ActNone;
          end
          if (rel_press && press_d < cfg_i.short_press_limit) begin
            if (rel_d <= cfg_i.click_gap_limit && cur_i.prior == ActPrimary) begin
              eval_o.ev_valid = 1'b1;
              eval_o.ev_code  = EvDouble;
              prior_d         = ActDouble;
            end else begin
              prior_d = ActPrimary;
            end
          end else if (down_i && press_d == cfg_i.long_press_time) begin
            eval_o.ev_valid = 1'b1;
            eval_o.ev_code  = EvLong;
            prior_d         = ActLong;
          end
        end
        default: ;
      endcase

      // release gap restarts on each release in the defined modes
      if (mode_i >= ModeCont && mode_i <= ModeTreble && rel_press) rel_d = '0;

      eval_o.hold = hold_key && down_i && press_d == HoldMs;

      if (!down_i) press_d = '0;
    end

    eval_o.next.press      = press_d;
    eval_o.next.release_ms = rel_d;
    eval_o.next.prior      = prior_d;
  end

endmodule

### rtl/core/kpe_event_fifo.sv
// ----------------------------------------------------------------------------
// kpe_event_fifo
// Small result queue that drives the output channel.
// ----------------------------------------------------------------------------
module kpe_event_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  kpe_pkg::out_item_t          push_data_i,
  output logic                        full_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output kpe_pkg::out_item_t          out_data_o
);
  import kpe_pkg::*;

  out_item_t           buf_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q;
  logic [FifoPtrW-1:0] rd_ptr_q;
  logic [FifoCntW-1:0] count_q;
  logic                pop;
  logic                push;

  assign full_o      = (count_q == FifoCntW'(FifoDepth));
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign push        = push_i && !full_o;
  assign out_data_o  = buf_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/key_press_event_classifier_core.sv
// ----------------------------------------------------------------------------
// key_press_event_classifier_core
// Classifies the press and release history of six keys into events, one
// scan tick per request, keeping all per-key state in one small memory.
//
//   channel  dir  signals                                    request
//   in       in   in_valid_i/in_ready_o, key_levels_i        one scan tick
//   out      out  out_valid_o/out_ready_i, key_index_o,      one key event
//                 event_code_o, last_event_o
//   cfg      in   cfg_valid_i/cfg_ready_o, cfg_index_i,      one register
//                 cfg_data_i
//
// A scan runs through accept, a memory read, the keys in turn and a closing
// state; a key with both a mode event and a long hold adds a hold state.
// The single read port allows one key a cycle while the result queue has room.
// Reset clears all key state at once through per-entry valid bits.
// When the four-entry result queue is full the key sequencer holds.
// ----------------------------------------------------------------------------
module key_press_event_classifier_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [kpe_pkg::LevelW-1:0]   key_levels_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [kpe_pkg::KeyW-1:0]     key_index_o,
  output logic [kpe_pkg::CodeW-1:0]    event_code_o,
  output logic                         last_event_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [kpe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kpe_pkg::CfgDatW-1:0]  cfg_data_i
);
  import kpe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_HD   = 3'd3;
  localparam logic [2:0] S_FL   = 3'd4;
  localparam logic [KeyW-1:0] LastKey = KeyW'(NUM_KEYS - 1);

  logic [2:0]        state_q, state_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [LevelW-1:0] levels_q;
  logic              pend_valid_q, pend_valid_d;
  logic [KeyW-1:0]   pend_key_q, pend_key_d;
  logic [CodeW-1:0]  pend_code_q, pend_code_d;

  cfg_t              cfg;
  key_state_t        rd_data;
  key_eval_t         eval;
  logic              rd_en;
  logic [KeyW-1:0]   rd_addr;
  logic              wr_en;
  logic              fifo_full;
  logic              push;
  out_item_t         push_data;
  out_item_t         out_data;
  logic              new_ev;
  logic [CodeW-1:0]  new_code;
  logic              accept;
  logic              down;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  kpe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // per-key state memory
  kpe_state_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (key_q),
    .wr_data_i (eval.next)
  );

  // key update for the key under work
  assign down = levels_q[key_q];

  kpe_key_eval u_eval (
    .cfg_i  (cfg),
    .key_i  (key_q),
    .down_i (down),
    .mode_i (cfg.key_modes[ModeW*key_q +: ModeW]),
    .cur_i  (rd_data),
    .eval_o (eval)
  );

  // scan sequencer with one-deep hold-back of the newest result
  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    pend_valid_d = pend_valid_q;
    pend_key_d   = pend_key_q;
    pend_code_d  = pend_code_q;
    rd_en        = 1'b0;
    rd_addr      = key_q + 1'b1;
    wr_en        = 1'b0;
    new_ev       = 1'b0;
    new_code     = EvHold;
    push         = 1'b0;
    push_data    = '{key: pend_key_q, code: pend_code_q, last: 1'b0};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RD;
          key_d   = '0;
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        rd_addr = key_q;
        state_d = S_EV;
      end
      S_EV: begin
        if (!fifo_full) begin
          wr_en    = 1'b1;
          new_ev   = eval.ev_valid || eval.hold;
          new_code = eval.ev_valid ? eval.ev_code : EvHold;
          if (key_q != LastKey) rd_en = 1'b1;
          if (eval.ev_valid && eval.hold) begin
            state_d = S_HD;
          end else if (key_q == LastKey) begin
            state_d = S_FL;
          end else begin
            key_d = key_q + 1'b1;
          end
        end
      end
      S_HD: begin
        if (!fifo_full) begin
          new_ev   = 1'b1;
          new_code = EvHold;
          if (key_q == LastKey) begin
            state_d = S_FL;
          end else begin
            key_d   = key_q + 1'b1;
            state_d = S_EV;
          end
        end
      end
      S_FL: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (!fifo_full) begin
          push           = 1'b1;
          push_data.last = 1'b1;
          pend_valid_d   = 1'b0;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // a new result releases the one held back
    if (new_ev) begin
      push         = pend_valid_q;
      pend_valid_d = 1'b1;
      pend_key_d   = key_q;
      pend_code_d  = new_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      key_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      key_q        <= key_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_key_q  <= pend_key_d;
    pend_code_q <= pend_code_d;
    if (accept) levels_q <= key_levels_i;
  end

  // result queue
  kpe_event_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign key_index_o  = out_data.key;
  assign event_code_o = out_data.code;
  assign last_event_o = out_data.last;

  // checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_full) else $error("result pushed into a full queue");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q) else $error("held result left after scan");

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (key_q <= LastKey)) else $error("state write beyond last key");

  a_accept_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RD && key_q == '0)) else $error("scan did not start at key 0");

  a_no_rw_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != key_q)) else $error("read and write hit one entry");

endmodule
